[design/msm_pkg.sv]
package msm_pkg;

  localparam int CHANNELS      = 8;
  localparam int CH_W          = $clog2(CHANNELS);
  localparam int SAMPLE_WORDS  = 65536;
  localparam int SADDR_W       = $clog2(SAMPLE_WORDS);
  localparam int LEN_W         = 17;
  localparam int OFS_W         = 16;
  localparam int GAIN_W        = 13;
  localparam int FRAME_W       = 32;
  localparam int TAG_W         = 16;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 13'h1000;
  localparam logic [LEN_W-1:0]  MAX_LEN    = 17'h10000;
  localparam logic signed [15:0] MIX_MIN   = -16'sd32768;
  localparam logic signed [15:0] MIX_MAX   = 16'sd32767;

  // One channel record as kept in the channel memory.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [15:0]        base;
    logic [LEN_W-1:0]   length;
    logic [OFS_W-1:0]   offset;
    logic [FRAME_W-1:0] begin_frame;
    logic [GAIN_W-1:0]  gain;
  } chan_t;

  localparam int CHAN_W = $bits(chan_t);

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_LOAD  = 3'd1,
    ACT_START = 3'd2,
    ACT_STOP  = 3'd3,
    ACT_VOL   = 3'd4,
    ACT_QUERY = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDCH,
    ST_CHAN,
    ST_SAMP,
    ST_MULT,
    ST_FIND,
    ST_GAIN,
    ST_DONE
  } state_t;

  // Saturating add of a scaled sample to the running mix.
  function automatic logic signed [15:0] sat_add(logic signed [15:0] acc,
                                                 logic signed [17:0] v);
    logic signed [18:0] s;
    s = 19'(acc) + 19'(v);
    if (s < 19'(MIX_MIN)) return MIX_MIN;
    if (s > 19'(MIX_MAX)) return MIX_MAX;
    return s[15:0];
  endfunction

endpackage

[design/msm_if.sv]
interface msm_in_if import msm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [15:0]       address;
  logic signed [15:0] sample_value;
  logic [16:0]       sound_length;
  logic [31:0]       start_frame;
  logic [15:0]       handle;
  logic              loop_flag;
  logic [12:0]       volume;
  modport source (output valid, action, address, sample_value, sound_length,
                  start_frame, handle, loop_flag, volume, input ready);
  modport sink (input valid, action, address, sample_value, sound_length,
                start_frame, handle, loop_flag, volume, output ready);
endinterface

interface msm_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] mixed_sample;
  logic [31:0]       frame_number;
  logic              accepted;
  logic              playing;
  modport source (output valid, mixed_sample, frame_number, accepted, playing,
                  input ready);
  modport sink (input valid, mixed_sample, frame_number, accepted, playing,
                output ready);
endinterface

[design/msm_ram.sv]
module msm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/msm_ctrl.sv]
module msm_ctrl import msm_pkg::*; (
  input  logic clk,
  input  logic rst,
  msm_in_if.sink   in_ch,
  msm_out_if.source out_ch,
  output logic                ch_we,
  output logic [CH_W-1:0]     ch_waddr,
  output chan_t               ch_wdata,
  output logic [CH_W-1:0]     ch_raddr,
  input  chan_t               ch_rdata,
  output logic                sm_we,
  output logic [SADDR_W-1:0]  sm_waddr,
  output logic [15:0]         sm_wdata,
  output logic [SADDR_W-1:0]  sm_raddr,
  input  logic [15:0]         sm_rdata
);
  state_t state, state_next;

  // Captured item.
  logic [2:0]         act;
  logic [15:0]        addr_q;
  logic [LEN_W-1:0]   len_q;
  logic [FRAME_W-1:0] sframe_q;
  logic [TAG_W-1:0]   handle_q;
  logic               loop_q;
  logic [GAIN_W-1:0]  vol_q;

  // Per-channel flags and tags live in flops so that the searches are combinational.
  logic [CHANNELS-1:0] active;
  logic [CHANNELS-1:0] loopf;
  logic [TAG_W-1:0]    tags [CHANNELS];

  logic [FRAME_W-1:0]  frame;
  logic [CH_W-1:0]     ch;
  logic                ch_last;
  chan_t               rec;
  logic signed [15:0]  acc;
  logic signed [28:0]  prod;
  logic                flag_acc, flag_play;

  logic                res_valid;
  logic                res_free;
  logic signed [15:0]  res_mix;
  logic [FRAME_W-1:0]  res_frame;
  logic                res_acc, res_play;

  logic [CHANNELS-1:0] match;
  logic                hit, free_any;
  logic [CH_W-1:0]     hit_ch, free_ch;

  always_comb begin
    hit = 1'b0;
    hit_ch = '0;
    free_any = 1'b0;
    free_ch = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      match[i] = active[i] && (tags[i] == handle_q) && (handle_q != '0);
      if (match[i]) begin
        hit = 1'b1;
        hit_ch = CH_W'(i);
      end
      if (!active[i]) begin
        free_any = 1'b1;
        free_ch = CH_W'(i);
      end
    end
  end

  // The start frame is checked on the record as it leaves the memory.
  logic [FRAME_W-1:0] diff;
  logic               due, at_end;
  assign diff   = ch_rdata.begin_frame - frame;
  assign due    = (diff == '0) || diff[FRAME_W-1];
  assign at_end = ({1'b0, rec.offset} + 17'd1) >= rec.length;

  // The result register may be refilled once its beat is taken.
  assign res_free = !res_valid || out_ch.ready;

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid        = res_valid;
  assign out_ch.mixed_sample = res_mix;
  assign out_ch.frame_number = res_frame;
  assign out_ch.accepted     = res_acc;
  assign out_ch.playing      = res_play;

  assign ch_raddr = (state == ST_FIND) ? hit_ch : ch;
  assign sm_raddr = SADDR_W'(rec.base + rec.offset);
  assign sm_we    = in_ch.valid && in_ch.ready && (in_ch.action == ACT_LOAD);
  assign sm_waddr = SADDR_W'(in_ch.address);
  assign sm_wdata = in_ch.sample_value;

  always_comb begin
    state_next = state;
    ch_we = 1'b0;
    ch_waddr = ch;
    ch_wdata = rec;
    unique case (state)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          state_next = (in_ch.action == ACT_TICK) ? ST_RDCH : ST_FIND;
        end
      end
      ST_RDCH: state_next = ST_CHAN;
      ST_CHAN: begin
        if (active[ch] && due) begin
          state_next = ST_SAMP;
        end else if (ch_last) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_RDCH;
        end
      end
      ST_SAMP: begin
        state_next = ST_MULT;
        if (at_end) begin
          ch_wdata.offset = '0;
        end else begin
          ch_wdata.offset = rec.offset + 16'd1;
        end
        ch_we = !at_end || loopf[ch];
      end
      ST_MULT: state_next = ch_last ? ST_DONE : ST_RDCH;
      ST_FIND: begin
        state_next = (act == ACT_VOL && hit) ? ST_GAIN : ST_DONE;
        if (act == ACT_START && free_any) begin
          ch_we = 1'b1;
          ch_waddr = free_ch;
          ch_wdata.tag = handle_q;
          ch_wdata.base = addr_q;
          ch_wdata.length = (len_q == '0) ? 17'd1 :
                            (len_q > MAX_LEN) ? MAX_LEN : len_q;
          ch_wdata.offset = '0;
          ch_wdata.begin_frame = sframe_q;
          ch_wdata.gain = UNITY_GAIN;
        end
      end
      ST_GAIN: begin
        // The hit channel's record was read in ST_FIND; only its gain changes.
        state_next = ST_DONE;
        ch_we = 1'b1;
        ch_wdata = ch_rdata;
        ch_wdata.gain = vol_q;
      end
      ST_DONE: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active <= '0;
      loopf <= '0;
      for (int i = 0; i < CHANNELS; i++) tags[i] <= '0;
      frame <= '0;
      res_valid <= 1'b0;
      ch <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            act <= in_ch.action;
            addr_q <= in_ch.address;
            len_q <= in_ch.sound_length;
            sframe_q <= in_ch.start_frame;
            handle_q <= in_ch.handle;
            loop_q <= in_ch.loop_flag;
            vol_q <= in_ch.volume;
            ch <= '0;
            ch_last <= (CHANNELS == 1);
            acc <= '0;
            flag_acc <= 1'b0;
            flag_play <= 1'b0;
          end
        end
        ST_RDCH: ;
        ST_CHAN: begin
          rec <= ch_rdata;
          if (!(active[ch] && due) && !ch_last) begin
            ch <= ch + CH_W'(1);
            ch_last <= (32'(ch) + 2 == CHANNELS);
          end
        end
        ST_SAMP: begin
          if (at_end && !loopf[ch]) begin
            active[ch] <= 1'b0;
            tags[ch] <= '0;
          end
        end
        ST_MULT: begin
          acc <= sat_add(acc, 18'(prod >>> 12));
          if (!ch_last) begin
            ch <= ch + CH_W'(1);
            ch_last <= (32'(ch) + 2 == CHANNELS);
          end
        end
        ST_FIND: begin
          if (act == ACT_START && free_any) begin
            active[free_ch] <= 1'b1;
            loopf[free_ch] <= loop_q;
            tags[free_ch] <= handle_q;
            flag_acc <= 1'b1;
          end else if (act == ACT_STOP && hit) begin
            active[hit_ch] <= 1'b0;
            tags[hit_ch] <= '0;
            flag_acc <= 1'b1;
          end else if (act == ACT_VOL && hit) begin
            ch <= hit_ch;
            flag_acc <= 1'b1;
          end else if (act == ACT_QUERY) begin
            flag_play <= hit;
          end
        end
        ST_GAIN: ;
        ST_DONE: begin
          if (res_free) begin
            res_mix <= (act == ACT_TICK) ? acc : '0;
            res_frame <= frame;
            res_acc <= flag_acc;
            res_play <= flag_play;
            if (act == ACT_TICK) frame <= frame + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Sample data arrives in ST_MULT; the product is formed and summed there.
  assign prod = 29'($signed(sm_rdata)) * 29'($signed({1'b0, rec.gain}));
endmodule

[design/multichannel_sample_mixer.sv]
// Channel  Dir  Content
// in_ch    in   action, address, sample_value, sound_length, start_frame,
//               handle, loop_flag, volume
// out_ch   out  mixed_sample, frame_number, accepted, playing
//
// One beat in gives one beat out, in order. A tick walks the channels one by
// one through the channel memory, reading each record (ST_RDCH, ST_CHAN)
// and, for a started, playing channel, its sample, which is scaled and summed
// (ST_SAMP, ST_MULT). Other actions pass through ST_FIND, and a set volume
// that finds its handle also through ST_GAIN (a record read-modify-write).
// rst is synchronous and clears the channel flags, tags and the frame
// counter; memories are not cleared. A stalled out_ch holds its beat; the
// next beat is still taken and worked, then waits for the output register
// and blocks in_ch until the held beat is taken.
module multichannel_sample_mixer import msm_pkg::*; (
  input logic clk,
  input logic rst,
  msm_in_if.sink    in_ch,
  msm_out_if.source out_ch
);
  logic               ch_we, sm_we;
  logic [CH_W-1:0]    ch_waddr, ch_raddr;
  chan_t              ch_wdata, ch_rdata;
  logic [SADDR_W-1:0] sm_waddr, sm_raddr;
  logic [15:0]        sm_wdata, sm_rdata;

  // The controller sequences every beat; both memories sit beside it.
  msm_ctrl u_ctrl (
    .clk, .rst, .in_ch, .out_ch,
    .ch_we, .ch_waddr, .ch_wdata, .ch_raddr, .ch_rdata,
    .sm_we, .sm_waddr, .sm_wdata, .sm_raddr, .sm_rdata
  );

  // One record per channel: tag, base, length, position, start frame and gain.
  msm_ram #(.WIDTH(CHAN_W), .DEPTH(CHANNELS)) u_chan_ram (
    .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  // Sample words as loaded; sound addresses wrap at the top of this memory.
  msm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_sample_ram (
    .clk, .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(sm_raddr), .rdata(sm_rdata)
  );
endmodule

[design/msm_checker.sv]
module msm_checker import msm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_accepted,
  input logic out_playing,
  input logic signed [15:0] out_mix
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_mix) && $stable(out_accepted) &&
    $stable(out_playing)) else $error("held result changed");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_accepted && out_playing)) else $error("flags clash");
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second beat too early");
endmodule

bind multichannel_sample_mixer msm_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_accepted(out_ch.accepted), .out_playing(out_ch.playing),
  .out_mix(out_ch.mixed_sample)
);
